// File: hw/rtl/cd_block_decoder_controller_macros.svh
// Assertion macros for the CD block decoder controller.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CD_BLOCK_DECODER_CONTROLLER_MACROS_SVH
`define CD_BLOCK_DECODER_CONTROLLER_MACROS_SVH

// Same-cycle implication
`define CDBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CDBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cdbd_pkg.sv
// Shared constants and codes for the CD block decoder controller.
// No dependencies.
package cdbd_pkg;

    localparam logic [3:0] OP_SET_ADDR = 4'd0;
    localparam logic [3:0] OP_REG_RD   = 4'd1;
    localparam logic [3:0] OP_REG_WR   = 4'd2;
    localparam logic [3:0] OP_DECODE   = 4'd3;
    localparam logic [3:0] OP_SECTOR   = 4'd4;
    localparam logic [3:0] OP_DMA      = 4'd5;
    localparam logic [3:0] OP_HOST_RD  = 4'd6;
    localparam logic [3:0] OP_TICK     = 4'd7;
    localparam logic [3:0] OP_DMA_ADDR = 4'd8;

    // read addresses
    localparam logic [4:0] R_IFSTAT = 5'h01;
    localparam logic [4:0] R_DBC_L  = 5'h02;
    localparam logic [4:0] R_DBC_H  = 5'h03;
    localparam logic [4:0] R_HEAD0  = 5'h04;
    localparam logic [4:0] R_HEAD1  = 5'h05;
    localparam logic [4:0] R_HEAD2  = 5'h06;
    localparam logic [4:0] R_HEAD3  = 5'h07;
    localparam logic [4:0] R_PT_L   = 5'h08;
    localparam logic [4:0] R_PT_H   = 5'h09;
    localparam logic [4:0] R_WA_L   = 5'h0A;
    localparam logic [4:0] R_WA_H   = 5'h0B;
    localparam logic [4:0] R_STAT0  = 5'h0C;
    localparam logic [4:0] R_STAT1  = 5'h0D;
    localparam logic [4:0] R_STAT2  = 5'h0E;
    localparam logic [4:0] R_STAT3  = 5'h0F;

    // write addresses
    localparam logic [4:0] W_COMIN  = 5'h00;
    localparam logic [4:0] W_IFCTRL = 5'h01;
    localparam logic [4:0] W_DBC_L  = 5'h02;
    localparam logic [4:0] W_DBC_H  = 5'h03;
    localparam logic [4:0] W_DAC_L  = 5'h04;
    localparam logic [4:0] W_DAC_H  = 5'h05;
    localparam logic [4:0] W_DTRG   = 5'h06;
    localparam logic [4:0] W_DTACK  = 5'h07;
    localparam logic [4:0] W_WA_L   = 5'h08;
    localparam logic [4:0] W_WA_H   = 5'h09;
    localparam logic [4:0] W_CTRL0  = 5'h0A;
    localparam logic [4:0] W_CTRL1  = 5'h0B;
    localparam logic [4:0] W_PT_L   = 5'h0C;
    localparam logic [4:0] W_PT_H   = 5'h0D;
    localparam logic [4:0] W_CTRL2  = 5'h0E;
    localparam logic [4:0] W_RESET  = 5'h0F;

    // destination codes
    localparam logic [2:0] DST_HOST0 = 3'd2;
    localparam logic [2:0] DST_HOST1 = 3'd3;
    localparam logic [2:0] DST_PCM   = 3'd4;
    localparam logic [2:0] DST_PRG   = 3'd5;
    localparam logic [2:0] DST_WRAM  = 3'd7;

    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_PCM  = 2'd1;
    localparam logic [1:0] TGT_PRG  = 2'd2;
    localparam logic [1:0] TGT_WRAM = 2'd3;

    // irq bits
    localparam int IRQ_DEC_EN = 0;
    localparam int IRQ_XFR_EN = 1;
    localparam int IRQ_CMD_EN = 2;
    localparam int IRQ_DEC_PD = 3;
    localparam int IRQ_XFR_PD = 4;
    localparam int IRQ_CMD_PD = 5;
    // status bits
    localparam int ST_ENABLE = 0;
    localparam int ST_ACTIVE = 1;
    localparam int ST_BUSY   = 2;
    localparam int ST_WAIT   = 3;
    // transfer bits
    localparam int TF_ENABLE = 0;
    localparam int TF_ACTIVE = 1;
    localparam int TF_BUSY   = 2;
    localparam int TF_WAIT   = 3;
    localparam int TF_READY  = 4;
    localparam int TF_DONE   = 5;
    // decoder bits
    localparam int DF_ENABLE = 0;
    localparam int DF_MODE   = 1;
    localparam int DF_FORM   = 2;
    localparam int DF_VALID  = 3;
    // control bits
    localparam int CB_WRITE_REQ = 2;
    localparam int CB_AUTO_CORR = 4;
    localparam int CB_HEAD      = 7;
    localparam int CB_FORM      = 9;
    localparam int CB_MODE      = 10;
    localparam int CB_CMD_BREAK = 18;

    localparam logic [15:0] BLOCK_BYTES = 16'd2352;
    localparam logic [16:0] SYNC_TAIL   = 17'd2340;
    localparam logic [16:0] SYNC_BYTES  = 17'd12;
    localparam logic [10:0] LAST_WORD   = 11'd1175;
    localparam logic [20:0] LEADIN      = 21'd150;
    localparam logic [19:0] WRAM_BASE0  = 20'h80000;
    localparam logic [19:0] WRAM_BASE1  = 20'hC0000;

    typedef struct packed {
        logic        start;
        logic [19:0] frame;
    } msf_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [23:0] header;
    } msf_rsp_t;

endpackage

// File: hw/rtl/cdbd_msf.sv
// Absolute frame to BCD minute/second/frame header, two-stage unit.
// Depends on cdbd_pkg.
module cdbd_msf
(
    input  logic               clk,
    input  logic               rst_n,
    input  cdbd_pkg::msf_req_t req,
    output cdbd_pkg::msf_rsp_t rsp
);

    localparam logic [19:0] RECIP75 = 20'd894785;  // ceil(2^26/75)
    localparam logic [13:0] RECIP60 = 14'd8739;    // ceil(2^19/60)

    logic        v1_reg;
    logic        v2_reg;
    logic [19:0] a_reg;
    logic [12:0] q75_reg;
    logic [12:0] q75b_reg;
    logic [6:0]  fr_reg;
    logic [7:0]  min_reg;
    logic [39:0] p1;
    logic [26:0] p2;
    logic [19:0] fr_wide;
    logic [12:0] sec_wide;

    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [18:0] t;
        logic [3:0]  tens;
        logic [7:0]  units;
        begin
            t     = 19'(v) * 19'd205;
            tens  = t[14:11];
            units = v - 8'(tens) * 8'd10;
            to_bcd = {tens, units[3:0]};
        end
    endfunction

    assign p1       = req.frame * RECIP75;
    assign fr_wide  = a_reg - 20'(q75_reg) * 20'd75;
    assign p2       = 27'(q75_reg) * 27'(RECIP60);
    assign sec_wide = q75b_reg - 13'(min_reg) * 13'd60;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= req.frame;
        q75_reg  <= p1[38:26];
        fr_reg   <= fr_wide[6:0];
        q75b_reg <= q75_reg;
        min_reg  <= p2[26:19];
    end

    assign rsp.busy   = v1_reg | v2_reg;
    assign rsp.done   = v2_reg;
    assign rsp.header = {to_bcd(min_reg), to_bcd(8'(sec_wide[5:0])), to_bcd(8'(fr_reg))};

endmodule

// File: hw/rtl/cd_block_decoder_controller.sv
// Top level of the CD block decoder controller: register file, transfer engine, buffer RAM.
// Depends on cdbd_pkg, cdbd_msf and cd_block_decoder_controller_macros.svh.
//
// Usage:
//   cfg channel: one write sets the transfer destination; write only while idle.
//   s channel: one command per transfer (operation in s_tuser). Each command
//   gives exactly one result transfer on the m channel.
//   Result path: a taken command passes the buffer RAM read stage, then the
//   output register, and its result is presented on m from that register.
//   Throughput: one command per cycle unless stalled; a decode command with the
//   decoder enabled holds s_tready low while the header unit converts the frame number.
//   Reset: after rst_n rises the buffer RAM is cleared one word a cycle,
//   all RAM_WORDS words, with s_tready low; cfg writes are taken throughout.
//   Stall: when m_tready is low the output register and one in-flight command
//   hold; s_tready drops only once both are occupied.
`include "cd_block_decoder_controller_macros.svh"
module cd_block_decoder_controller
#(
    parameter int RAM_WORDS = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,   // transfer_destination
    input  logic        s_tvalid,
    output logic        s_tready,
    // reg_address, write_byte, sector_number, word_index, sector_word, dma_start,
    // wram_bank, zero pad
    input  logic [87:0] s_tdata,
    input  logic [3:0]  s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_byte, host_word, dma_bus_address, dma_word, irq_line, stopwatch_value,
    // zero pad
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser     // dma_write, dma_target
);

    localparam int AW = $clog2(RAM_WORDS);
    localparam int QB = $clog2((65536 + RAM_WORDS - 1) / RAM_WORDS) + 1;

    // fields
    logic [3:0]         op;
    logic [4:0]         f_addr;
    logic [7:0]         f_byte;
    logic signed [19:0] f_sector;
    logic [10:0]        f_widx;
    logic [15:0]        f_word;
    logic [19:0]        f_dma;
    logic               f_bank;

    assign op       = s_tuser;
    assign f_addr   = s_tdata[4:0];
    assign f_byte   = s_tdata[12:5];
    assign f_sector = s_tdata[32:13];
    assign f_widx   = s_tdata[43:33];
    assign f_word   = s_tdata[59:44];
    assign f_dma    = s_tdata[79:60];
    assign f_bank   = s_tdata[80];

    // state
    logic [2:0]  dest_reg;
    logic [4:0]  cur_reg, cur_next;
    logic [11:0] tick_reg, tick_next;
    logic [5:0]  irq_reg, irq_next;
    logic [3:0]  st_reg, st_next;
    logic [5:0]  tf_reg, tf_next;
    logic [19:0] dadr_reg, dadr_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] tgt_reg, tgt_next;
    logic [15:0] bp_reg, bp_next;
    logic [15:0] bc_reg, bc_next;
    logic [19:0] cb_reg, cb_next;
    logic [3:0]  df_reg, df_next;
    logic [23:0] hdr_reg, hdr_next;
    logic        hmode_reg, hmode_next;
    logic        armed_reg, armed_next;

    // clearing pass
    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    // pipeline
    logic        s1_v_reg;
    logic [7:0]  s1_rd_reg;
    logic        s1_host_reg;
    logic        s1_dma_reg;
    logic [1:0]  s1_tgt_reg;
    logic [19:0] s1_da_reg;
    logic        s1_irq_reg;
    logic [11:0] s1_tick_reg;
    logic        out_v_reg;
    logic [79:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        s1_move;
    logic        accept;

    // memory
    logic [15:0]   ram [RAM_WORDS];
    logic [15:0]   rdata_reg;
    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          re;
    logic [AW-1:0] ra;

    // header unit
    cdbd_pkg::msf_req_t msf_req;
    cdbd_pkg::msf_rsp_t msf_rsp;

    // combinational results
    logic [7:0]  rd;
    logic        host_hit;
    logic        dma_hit;
    logic [1:0]  dtgt;
    logic [19:0] dbus;
    logic        st_we;
    logic [AW-1:0] st_addr;
    logic [20:0] fr_s;
    logic        do_count;

    function automatic logic [AW-1:0] wrap(input logic [15:0] x);
        logic [16:0] r;
        begin
            r = 17'(x);
            for (int j = QB - 1; j >= 0; j--)
            begin
                if (r >= (17'(RAM_WORDS) << j))
                begin
                    r = r - (17'(RAM_WORDS) << j);
                end
            end
            wrap = r[AW-1:0];
        end
    endfunction

    cdbd_msf u_msf
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (msf_req),
        .rsp   (msf_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s1_move   = s1_v_reg & (~out_v_reg | m_tready);
    assign s_tready  = ~clr_reg & ~msf_rsp.busy & (~s1_v_reg | s1_move);
    assign accept    = s_tvalid & s_tready;

    always_comb
    begin
        logic [16:0] off;
        logic [16:0] sum;
        logic        fin;
        cur_next   = cur_reg;
        tick_next  = tick_reg;
        irq_next   = irq_reg;
        st_next    = st_reg;
        tf_next    = tf_reg;
        dadr_next  = dadr_reg;
        src_next   = src_reg;
        tgt_next   = tgt_reg;
        bp_next    = bp_reg;
        bc_next    = bc_reg;
        cb_next    = cb_reg;
        df_next    = df_reg;
        hdr_next   = hdr_reg;
        hmode_next = hmode_reg;
        armed_next = armed_reg;
        rd         = 8'hFF;
        host_hit   = 1'b0;
        dma_hit    = 1'b0;
        dtgt       = cdbd_pkg::TGT_NONE;
        dbus       = 20'd0;
        st_we      = 1'b0;
        st_addr    = '0;
        do_count   = 1'b0;
        msf_req.start = 1'b0;
        fr_s       = 21'(f_sector) + cdbd_pkg::LEADIN;
        msf_req.frame = fr_s[20] ? 20'd0 : fr_s[19:0];
        off        = 17'(f_widx) << 1;
        sum        = 17'd0;
        fin        = 1'b0;

        if (msf_rsp.done)
        begin
            hdr_next = msf_rsp.header;
        end

        if (accept)
        begin
            case (op)
                cdbd_pkg::OP_SET_ADDR:
                begin
                    cur_next = f_addr;
                end
                cdbd_pkg::OP_REG_RD:
                begin
                    case (cur_reg)
                        cdbd_pkg::R_IFSTAT:
                        begin
                            rd = {~irq_reg[cdbd_pkg::IRQ_CMD_PD], ~irq_reg[cdbd_pkg::IRQ_XFR_PD],
                                  ~irq_reg[cdbd_pkg::IRQ_DEC_PD], 1'b1,
                                  ~tf_reg[cdbd_pkg::TF_BUSY], ~st_reg[cdbd_pkg::ST_BUSY],
                                  ~tf_reg[cdbd_pkg::TF_ACTIVE], ~st_reg[cdbd_pkg::ST_ACTIVE]};
                        end
                        cdbd_pkg::R_DBC_L: rd = bc_reg[7:0];
                        cdbd_pkg::R_DBC_H: rd = {4'd0, bc_reg[11:8]};
                        cdbd_pkg::R_HEAD0: rd = cb_reg[cdbd_pkg::CB_HEAD] ? 8'd0 : hdr_reg[23:16];
                        cdbd_pkg::R_HEAD1: rd = cb_reg[cdbd_pkg::CB_HEAD] ? 8'd0 : hdr_reg[15:8];
                        cdbd_pkg::R_HEAD2: rd = cb_reg[cdbd_pkg::CB_HEAD] ? 8'd0 : hdr_reg[7:0];
                        cdbd_pkg::R_HEAD3:
                        begin
                            rd = cb_reg[cdbd_pkg::CB_HEAD] ? 8'd0 : {7'd0, hmode_reg};
                        end
                        cdbd_pkg::R_PT_L:  rd = bp_reg[7:0];
                        cdbd_pkg::R_PT_H:  rd = bp_reg[15:8];
                        cdbd_pkg::R_WA_L:  rd = tgt_reg[7:0];
                        cdbd_pkg::R_WA_H:  rd = tgt_reg[15:8];
                        cdbd_pkg::R_STAT0: rd = {df_reg[cdbd_pkg::DF_ENABLE], 7'd0};
                        cdbd_pkg::R_STAT1: rd = 8'd0;
                        cdbd_pkg::R_STAT2:
                        begin
                            rd = {4'd0, df_reg[cdbd_pkg::DF_MODE], df_reg[cdbd_pkg::DF_FORM], 2'd0};
                        end
                        cdbd_pkg::R_STAT3:
                        begin
                            rd = {~df_reg[cdbd_pkg::DF_VALID], 7'd0};
                            df_next[cdbd_pkg::DF_VALID]   = 1'b0;
                            irq_next[cdbd_pkg::IRQ_DEC_PD] = 1'b0;
                        end
                        default: rd = 8'hFF;
                    endcase
                    if (cur_reg != 5'd0)
                    begin
                        cur_next = cur_reg + 5'd1;
                    end
                end
                cdbd_pkg::OP_REG_WR:
                begin
                    case (cur_reg)
                        cdbd_pkg::W_COMIN:
                        begin
                            if (!(st_reg[cdbd_pkg::ST_WAIT] && tf_reg[cdbd_pkg::TF_BUSY]))
                            begin
                                st_next[cdbd_pkg::ST_ACTIVE] = 1'b1;
                                st_next[cdbd_pkg::ST_BUSY]   = 1'b1;
                            end
                        end
                        cdbd_pkg::W_IFCTRL:
                        begin
                            st_next[cdbd_pkg::ST_ENABLE]    = f_byte[0];
                            st_next[cdbd_pkg::ST_WAIT]      = ~f_byte[2];
                            tf_next[cdbd_pkg::TF_ENABLE]    = f_byte[1];
                            tf_next[cdbd_pkg::TF_WAIT]      = ~f_byte[3];
                            cb_next[cdbd_pkg::CB_CMD_BREAK] = ~f_byte[4];
                            irq_next[2:0] = f_byte[7:5];
                            if (!f_byte[1])
                            begin
                                tf_next[cdbd_pkg::TF_ACTIVE] = 1'b0;
                                tf_next[cdbd_pkg::TF_BUSY]   = 1'b0;
                                tf_next[cdbd_pkg::TF_READY]  = 1'b0;
                            end
                        end
                        cdbd_pkg::W_DBC_L: bc_next[7:0]   = f_byte;
                        cdbd_pkg::W_DBC_H: bc_next[15:8]  = {4'd0, f_byte[3:0]};
                        cdbd_pkg::W_DAC_L: src_next[7:0]  = f_byte;
                        cdbd_pkg::W_DAC_H: src_next[15:8] = f_byte;
                        cdbd_pkg::W_DTRG:
                        begin
                            if (tf_reg[cdbd_pkg::TF_ENABLE])
                            begin
                                tf_next[cdbd_pkg::TF_ACTIVE] = 1'b1;
                                tf_next[cdbd_pkg::TF_BUSY]   = 1'b1;
                                tf_next[cdbd_pkg::TF_DONE]   = 1'b0;
                                tf_next[cdbd_pkg::TF_READY]  =
                                    (dest_reg == cdbd_pkg::DST_HOST0) ||
                                    (dest_reg == cdbd_pkg::DST_HOST1);
                                irq_next[cdbd_pkg::IRQ_XFR_PD] = 1'b0;
                            end
                        end
                        cdbd_pkg::W_DTACK: irq_next[cdbd_pkg::IRQ_XFR_PD] = 1'b0;
                        cdbd_pkg::W_WA_L:  tgt_next[7:0]  = f_byte;
                        cdbd_pkg::W_WA_H:  tgt_next[15:8] = f_byte;
                        cdbd_pkg::W_CTRL0:
                        begin
                            cb_next[6:0] = f_byte[6:0];
                            df_next[cdbd_pkg::DF_ENABLE] = f_byte[7];
                            df_next[cdbd_pkg::DF_MODE]   = cb_next[cdbd_pkg::CB_MODE];
                            df_next[cdbd_pkg::DF_FORM]   =
                                cb_next[cdbd_pkg::CB_FORM] & cb_next[cdbd_pkg::CB_AUTO_CORR];
                        end
                        cdbd_pkg::W_CTRL1:
                        begin
                            cb_next[14:7] = f_byte;
                            df_next[cdbd_pkg::DF_MODE] = cb_next[cdbd_pkg::CB_MODE];
                            df_next[cdbd_pkg::DF_FORM] =
                                cb_next[cdbd_pkg::CB_FORM] & cb_next[cdbd_pkg::CB_AUTO_CORR];
                        end
                        cdbd_pkg::W_PT_L:  bp_next[7:0]   = f_byte;
                        cdbd_pkg::W_PT_H:  bp_next[15:8]  = f_byte;
                        cdbd_pkg::W_CTRL2: cb_next[17:15] = f_byte[2:0];
                        cdbd_pkg::W_RESET:
                        begin
                            st_next    = 4'd0;
                            st_next[cdbd_pkg::ST_WAIT] = 1'b1;
                            tf_next    = 6'd0;
                            tf_next[cdbd_pkg::TF_DONE] = tf_reg[cdbd_pkg::TF_DONE];
                            tf_next[cdbd_pkg::TF_WAIT] = 1'b1;
                            irq_next   = 6'd0;
                            cb_next    = 20'd0;
                            df_next    = 4'd0;
                            hdr_next   = 24'd0;
                            hmode_next = 1'b0;
                            armed_next = 1'b0;
                        end
                        default: ;
                    endcase
                    if (cur_reg != 5'd0)
                    begin
                        cur_next = cur_reg + 5'd1;
                    end
                end
                cdbd_pkg::OP_DECODE:
                begin
                    armed_next = 1'b0;
                    if (df_reg[cdbd_pkg::DF_ENABLE])
                    begin
                        msf_req.start = 1'b1;
                        hmode_next = 1'b1;
                        df_next[cdbd_pkg::DF_VALID]    = 1'b1;
                        irq_next[cdbd_pkg::IRQ_DEC_PD] = 1'b1;
                        if (cb_reg[cdbd_pkg::CB_WRITE_REQ] && !f_sector[19])
                        begin
                            bp_next    = bp_reg + cdbd_pkg::BLOCK_BYTES;
                            tgt_next   = tgt_reg + cdbd_pkg::BLOCK_BYTES;
                            armed_next = 1'b1;
                        end
                    end
                end
                cdbd_pkg::OP_SECTOR:
                begin
                    if (armed_reg && f_widx <= cdbd_pkg::LAST_WORD)
                    begin
                        // sync bytes go to the block tail
                        if (off < cdbd_pkg::SYNC_BYTES)
                        begin
                            sum = 17'(bp_reg) + off + cdbd_pkg::SYNC_TAIL;
                        end
                        else
                        begin
                            sum = 17'(bp_reg) + off - cdbd_pkg::SYNC_BYTES;
                        end
                        st_we   = 1'b1;
                        st_addr = wrap(sum[16:1]);
                    end
                end
                cdbd_pkg::OP_DMA:
                begin
                    if (tf_reg[cdbd_pkg::TF_ACTIVE] &&
                        (dest_reg == cdbd_pkg::DST_PCM || dest_reg == cdbd_pkg::DST_PRG ||
                         dest_reg == cdbd_pkg::DST_WRAM))
                    begin
                        dma_hit  = 1'b1;
                        do_count = 1'b1;
                        if (dest_reg == cdbd_pkg::DST_PCM)
                        begin
                            dtgt      = cdbd_pkg::TGT_PCM;
                            dbus      = {dadr_reg[19:1], 1'b0};
                            dadr_next = dadr_reg + 20'd4;
                        end
                        else if (dest_reg == cdbd_pkg::DST_PRG)
                        begin
                            dtgt      = cdbd_pkg::TGT_PRG;
                            dbus      = {dadr_reg[19:1], 1'b0};
                            dadr_next = dadr_reg + 20'd2;
                        end
                        else
                        begin
                            dtgt      = cdbd_pkg::TGT_WRAM;
                            dbus      = (f_bank ? cdbd_pkg::WRAM_BASE1 : cdbd_pkg::WRAM_BASE0) |
                                        {dadr_reg[19:1], 1'b0};
                            dadr_next = dadr_reg + 20'd2;
                        end
                    end
                end
                cdbd_pkg::OP_HOST_RD:
                begin
                    if (tf_reg[cdbd_pkg::TF_READY])
                    begin
                        host_hit = 1'b1;
                        do_count = 1'b1;
                    end
                end
                cdbd_pkg::OP_TICK:     tick_next = tick_reg + 12'd1;
                cdbd_pkg::OP_DMA_ADDR: dadr_next = f_dma;
                default: ;
            endcase

            if (do_count)
            begin
                src_next = src_reg + 16'd2;
                bc_next  = bc_reg - 16'd2;
                fin      = (bc_reg == 16'd0) || (bc_reg == 16'd1);
                if (fin)
                begin
                    tf_next[cdbd_pkg::TF_ACTIVE] = 1'b0;
                    tf_next[cdbd_pkg::TF_BUSY]   = 1'b0;
                    tf_next[cdbd_pkg::TF_READY]  = 1'b0;
                    tf_next[cdbd_pkg::TF_DONE]   = 1'b1;
                    irq_next[cdbd_pkg::IRQ_XFR_PD] = 1'b1;
                end
            end
        end
    end

    // buffer RAM port control
    assign we = clr_reg | st_we;
    assign wa = clr_reg ? clr_cnt_reg : st_addr;
    assign wd = clr_reg ? 16'd0 : f_word;
    assign re = accept & (host_hit | dma_hit);
    assign ra = wrap({1'b0, src_reg[15:1]});

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[wa] <= wd;
        end
        if (re)
        begin
            rdata_reg <= ram[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg    <= 3'd0;
            cur_reg     <= 5'd0;
            tick_reg    <= 12'd0;
            irq_reg     <= 6'd0;
            st_reg      <= 4'd0;
            tf_reg      <= 6'd0;
            dadr_reg    <= 20'd0;
            src_reg     <= 16'd0;
            tgt_reg     <= 16'd0;
            bp_reg      <= 16'd0;
            bc_reg      <= 16'd0;
            cb_reg      <= 20'd0;
            df_reg      <= 4'd0;
            hdr_reg     <= 24'd0;
            hmode_reg   <= 1'b0;
            armed_reg   <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            s1_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                dest_reg <= cfg_data;
            end
            cur_reg   <= cur_next;
            tick_reg  <= tick_next;
            irq_reg   <= irq_next;
            st_reg    <= st_next;
            tf_reg    <= tf_next;
            dadr_reg  <= dadr_next;
            src_reg   <= src_next;
            tgt_reg   <= tgt_next;
            bp_reg    <= bp_next;
            bc_reg    <= bc_next;
            cb_reg    <= cb_next;
            df_reg    <= df_next;
            hdr_reg   <= hdr_next;
            hmode_reg <= hmode_next;
            armed_reg <= armed_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(RAM_WORDS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_v_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg   <= rd;
            s1_host_reg <= host_hit;
            s1_dma_reg  <= dma_hit;
            s1_tgt_reg  <= dtgt;
            s1_da_reg   <= dbus;
            s1_irq_reg  <= |(irq_next[2:0] & irq_next[5:3]);
            s1_tick_reg <= tick_next;
        end
        if (s1_move)
        begin
            out_data_reg <= {7'd0, s1_tick_reg, s1_irq_reg,
                             s1_dma_reg ? rdata_reg : 16'd0, s1_da_reg,
                             s1_host_reg ? rdata_reg : 16'hFFFF, s1_rd_reg};
            out_user_reg <= {s1_tgt_reg, s1_dma_reg};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `CDBD_ASSERT_IMP(a_clr_blocks, clr_reg, !s_tready, "input taken during RAM clear")
    `CDBD_ASSERT_IMP(a_msf_blocks, msf_rsp.busy, !s_tready, "input taken during header conversion")
    `CDBD_ASSERT_NXT(a_s1_hold, s1_v_reg && !s1_move, s1_v_reg, "in-flight command lost")
    `CDBD_ASSERT_IMP(a_tgt_none, m_tvalid && !m_tuser[0], m_tuser[2:1] == cdbd_pkg::TGT_NONE,
                     "target without DMA write")

endmodule
